// File: rtl/core/gif_lzw_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef GIF_LZW_ENCODER_TOP_DEFINES_SVH
`define GIF_LZW_ENCODER_TOP_DEFINES_SVH

// Checks that a condition implies another on the same clock edge.
`define GLZW_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("glzw check failed");

// Checks that a condition implies another on the next clock edge.
`define GLZW_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("glzw check failed");

`endif

// File: rtl/core/glzw_pkg.sv
package glzw_pkg;

    localparam int HASH_ENTRIES_DEF   = 8192;
    localparam int SUBBLOCK_BYTES_DEF = 255;

    localparam logic [11:0] MAX_CODE      = 12'd4095;
    localparam logic [3:0]  CODE_SIZE_RST = 4'd8;
    localparam logic [3:0]  CODE_SIZE_MIN = 4'd2;
    localparam logic [3:0]  MAX_WIDTH     = 4'd12;
    localparam int          ENTRY_W       = 33;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SWEEP = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_CMP   = 10'b0000001000,
        S_ADD   = 10'b0000010000,
        S_BYTE  = 10'b0000100000,
        S_FLUSH = 10'b0001000000,
        S_DONE  = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        J_START_CLR = 3'd0,
        J_MISS_PFX  = 3'd1,
        J_FULL_CLR  = 3'd2,
        J_LAST_PFX  = 3'd3,
        J_END_CODE  = 3'd4
    } job_t;

endpackage

// File: rtl/core/glzw_dict.sv
module glzw_dict #(
    parameter int DEPTH = glzw_pkg::HASH_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [glzw_pkg::ENTRY_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [glzw_pkg::ENTRY_W-1:0] rdata
);

    logic [glzw_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [glzw_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gif_lzw_encoder_top.sv
// Takes one pixel at a time: in_stall is high whenever the FSM is not in S_IDLE. A dictionary
// hit reads the entry in S_RD and compares it in S_CMP; each extra probe repeats both states.
// A miss adds the prefix code in S_ADD and sends out each whole byte from S_BYTE. The last
// pixel adds its end code and flush words; output stalls hold S_BYTE, S_FLUSH and S_DONE.
// The first pixel of each stream and every dictionary reset sweep all HASH_ENTRIES entries.
// Reset (rst_n low, asynchronous) clears all control state and sets code_size to 8.
module gif_lzw_encoder_top #(
    parameter int HASH_ENTRIES   = glzw_pkg::HASH_ENTRIES_DEF,
    parameter int SUBBLOCK_BYTES = glzw_pkg::SUBBLOCK_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pixel,
    input  logic       last_pixel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       block_end,
    output logic       stream_end,
    output logic       last
);

    `include "gif_lzw_encoder_top_defines.svh"

    localparam int AW = $clog2(HASH_ENTRIES);

    glzw_pkg::state_t state_reg, state_next;
    glzw_pkg::job_t   job_reg, job_next;

    logic [3:0]    code_size_reg, code_size_next;
    logic [3:0]    asize_reg, asize_next;
    logic [7:0]    pix_reg, pix_next;
    logic          lastp_reg, lastp_next;
    logic [11:0]   prefix_reg, prefix_next;
    logic [11:0]   ncode_reg, ncode_next;
    logic [3:0]    width_reg, width_next;
    logic [23:0]   acc_reg, acc_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [7:0]    sub_reg, sub_next;
    logic          first_reg, first_next;
    logic [19:0]   key_reg, key_next;
    logic [AW-1:0] hash_reg, hash_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          full_reg, full_next;
    logic [11:0]   code_reg, code_next;
    logic          pend_v_reg, pend_v_next;
    logic [7:0]    pend_b_reg, pend_b_next;
    logic          pend_be_reg, pend_be_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic          obe_reg, obe_next;
    logic          ose_reg, ose_next;
    logic          ol_reg, ol_next;

    logic                         we;
    logic [AW-1:0]                waddr;
    logic [glzw_pkg::ENTRY_W-1:0] wdata;
    logic [glzw_pkg::ENTRY_W-1:0] rdata;

    logic        out_free;
    logic        can_push;
    logic        produce;
    logic [7:0]  prod_byte;
    logic [8:0]  sub_inc;
    logic [7:0]  pmask;
    logic [7:0]  pval;
    logic [11:0] clear_code;
    logic [19:0] key_calc;
    logic [19:0] hmix;
    logic [3:0]  csize;
    logic [12:0] wlimit;

    glzw_dict #(
        .DEPTH(HASH_ENTRIES)
    ) u_dict (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(hash_reg),
        .rdata(rdata)
    );

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != glzw_pkg::S_IDLE);
    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign block_end  = obe_reg;
    assign stream_end = ose_reg;
    assign last       = ol_reg;

    assign out_free   = !ov_reg || !out_stall;
    assign can_push   = !pend_v_reg || out_free;
    assign pmask      = ~(8'hff << asize_reg);
    assign pval       = pix_reg & pmask;
    assign clear_code = 12'd1 << asize_reg;
    assign key_calc   = ({8'd0, prefix_reg} << asize_reg) + {12'd0, pixel & pmask};
    assign hmix       = key_calc ^ {12'd0, key_calc[19:12]};
    assign sub_inc    = {1'b0, sub_reg} + 9'd1;
    assign wlimit     = 13'd1 << width_reg;
    assign csize      = (cfg_data < glzw_pkg::CODE_SIZE_MIN) ? glzw_pkg::CODE_SIZE_MIN :
                        (cfg_data > glzw_pkg::CODE_SIZE_RST) ? glzw_pkg::CODE_SIZE_RST :
                        cfg_data;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        code_size_next = code_size_reg;
        asize_next     = asize_reg;
        pix_next       = pix_reg;
        lastp_next     = lastp_reg;
        prefix_next    = prefix_reg;
        ncode_next     = ncode_reg;
        width_next     = width_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        sub_next       = sub_reg;
        first_next     = first_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        sweep_next     = sweep_reg;
        full_next      = full_reg;
        code_next      = code_reg;
        pend_v_next    = pend_v_reg;
        pend_b_next    = pend_b_reg;
        pend_be_next   = pend_be_reg;
        ov_next        = ov_reg && out_stall;
        ob_next        = ob_reg;
        obe_next       = obe_reg;
        ose_next       = ose_reg;
        ol_next        = ol_reg;
        we             = 1'b0;
        waddr          = sweep_reg;
        wdata          = '0;
        produce        = 1'b0;
        prod_byte      = acc_reg[7:0];

        if (cfg_valid && cfg_ready)
        begin
            code_size_next = csize;
        end

        case (state_reg)
            glzw_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next   = pixel;
                    lastp_next = last_pixel;
                    if (!first_reg)
                    begin
                        asize_next  = code_size_reg;
                        ncode_next  = (12'd1 << code_size_reg) + 12'd2;
                        width_next  = code_size_reg + 4'd1;
                        acc_next    = '0;
                        cnt_next    = '0;
                        sub_next    = '0;
                        prefix_next = '0;
                        first_next  = 1'b1;
                        sweep_next  = '0;
                        full_next   = 1'b0;
                        state_next  = glzw_pkg::S_SWEEP;
                    end
                    else
                    begin
                        key_next   = key_calc;
                        hash_next  = hmix[AW-1:0];
                        state_next = glzw_pkg::S_RD;
                    end
                end
            end
            glzw_pkg::S_SWEEP:
            begin
                we         = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (&sweep_reg)
                begin
                    if (!full_reg)
                    begin
                        code_next  = clear_code;
                        job_next   = glzw_pkg::J_START_CLR;
                        state_next = glzw_pkg::S_ADD;
                    end
                    else if (lastp_reg)
                    begin
                        code_next  = prefix_reg;
                        job_next   = glzw_pkg::J_LAST_PFX;
                        state_next = glzw_pkg::S_ADD;
                    end
                    else
                    begin
                        state_next = glzw_pkg::S_DONE;
                    end
                end
            end
            glzw_pkg::S_RD:
            begin
                state_next = glzw_pkg::S_CMP;
            end
            glzw_pkg::S_CMP:
            begin
                if (!rdata[32])
                begin
                    code_next  = prefix_reg;
                    job_next   = glzw_pkg::J_MISS_PFX;
                    state_next = glzw_pkg::S_ADD;
                end
                else if (rdata[31:12] == key_reg)
                begin
                    prefix_next = rdata[11:0];
                    if (lastp_reg)
                    begin
                        code_next  = rdata[11:0];
                        job_next   = glzw_pkg::J_LAST_PFX;
                        state_next = glzw_pkg::S_ADD;
                    end
                    else
                    begin
                        state_next = glzw_pkg::S_DONE;
                    end
                end
                else
                begin
                    hash_next  = hash_reg + AW'(1);
                    state_next = glzw_pkg::S_RD;
                end
            end
            glzw_pkg::S_ADD:
            begin
                acc_next   = acc_reg | ({12'd0, code_reg & ~(12'hfff << width_reg)} << cnt_reg);
                cnt_next   = cnt_reg + {1'b0, width_reg};
                state_next = glzw_pkg::S_BYTE;
            end
            glzw_pkg::S_BYTE:
            begin
                if (cnt_reg >= 5'd8)
                begin
                    if (can_push)
                    begin
                        produce  = 1'b1;
                        acc_next = acc_reg >> 8;
                        cnt_next = cnt_reg - 5'd8;
                    end
                end
                else
                begin
                    if (({1'b0, ncode_reg} >= wlimit) && (width_reg < glzw_pkg::MAX_WIDTH))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                    case (job_reg)
                        glzw_pkg::J_START_CLR,
                        glzw_pkg::J_MISS_PFX:
                        begin
                            prefix_next = {4'd0, pval};
                            if ((job_reg == glzw_pkg::J_MISS_PFX) &&
                                (ncode_reg >= glzw_pkg::MAX_CODE))
                            begin
                                code_next  = clear_code;
                                job_next   = glzw_pkg::J_FULL_CLR;
                                state_next = glzw_pkg::S_ADD;
                            end
                            else
                            begin
                                if (job_reg == glzw_pkg::J_MISS_PFX)
                                begin
                                    we         = 1'b1;
                                    waddr      = hash_reg;
                                    wdata      = {1'b1, key_reg, ncode_reg};
                                    ncode_next = ncode_reg + 12'd1;
                                end
                                if (lastp_reg)
                                begin
                                    code_next  = {4'd0, pval};
                                    job_next   = glzw_pkg::J_LAST_PFX;
                                    state_next = glzw_pkg::S_ADD;
                                end
                                else
                                begin
                                    state_next = glzw_pkg::S_DONE;
                                end
                            end
                        end
                        glzw_pkg::J_FULL_CLR:
                        begin
                            ncode_next = clear_code + 12'd2;
                            width_next = asize_reg + 4'd1;
                            sweep_next = '0;
                            full_next  = 1'b1;
                            state_next = glzw_pkg::S_SWEEP;
                        end
                        glzw_pkg::J_LAST_PFX:
                        begin
                            code_next  = clear_code + 12'd1;
                            job_next   = glzw_pkg::J_END_CODE;
                            state_next = glzw_pkg::S_ADD;
                        end
                        default:
                        begin
                            state_next = glzw_pkg::S_FLUSH;
                        end
                    endcase
                end
            end
            glzw_pkg::S_FLUSH:
            begin
                if (cnt_reg != 5'd0)
                begin
                    if (can_push)
                    begin
                        produce  = 1'b1;
                        acc_next = acc_reg >> 8;
                        cnt_next = (cnt_reg > 5'd8) ? cnt_reg - 5'd8 : 5'd0;
                    end
                end
                else
                begin
                    acc_next   = '0;
                    state_next = glzw_pkg::S_DONE;
                end
            end
            glzw_pkg::S_DONE:
            begin
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        ov_next     = 1'b1;
                        ob_next     = pend_b_reg;
                        obe_next    = pend_be_reg || lastp_reg;
                        ose_next    = lastp_reg;
                        ol_next     = 1'b1;
                        pend_v_next = 1'b0;
                    end
                    if (lastp_reg)
                    begin
                        first_next  = 1'b0;
                        sub_next    = '0;
                        prefix_next = '0;
                    end
                    state_next = glzw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = glzw_pkg::S_IDLE;
            end
        endcase

        if (produce)
        begin
            if (sub_inc >= 9'(SUBBLOCK_BYTES))
            begin
                pend_be_next = 1'b1;
                sub_next     = '0;
            end
            else
            begin
                pend_be_next = 1'b0;
                sub_next     = sub_inc[7:0];
            end
            if (pend_v_reg)
            begin
                ov_next  = 1'b1;
                ob_next  = pend_b_reg;
                obe_next = pend_be_reg;
                ose_next = 1'b0;
                ol_next  = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_b_next = prod_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glzw_pkg::S_IDLE;
            job_reg       <= glzw_pkg::J_START_CLR;
            code_size_reg <= glzw_pkg::CODE_SIZE_RST;
            asize_reg     <= glzw_pkg::CODE_SIZE_RST;
            prefix_reg    <= '0;
            ncode_reg     <= (12'd1 << glzw_pkg::CODE_SIZE_RST) + 12'd2;
            width_reg     <= glzw_pkg::CODE_SIZE_RST + 4'd1;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            sub_reg       <= '0;
            first_reg     <= 1'b0;
            full_reg      <= 1'b0;
            sweep_reg     <= '0;
            pend_v_reg    <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            code_size_reg <= code_size_next;
            asize_reg     <= asize_next;
            prefix_reg    <= prefix_next;
            ncode_reg     <= ncode_next;
            width_reg     <= width_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            sub_reg       <= sub_next;
            first_reg     <= first_next;
            full_reg      <= full_next;
            sweep_reg     <= sweep_next;
            pend_v_reg    <= pend_v_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        lastp_reg   <= lastp_next;
        key_reg     <= key_next;
        hash_reg    <= hash_next;
        code_reg    <= code_next;
        pend_b_reg  <= pend_b_next;
        pend_be_reg <= pend_be_next;
        ob_reg      <= ob_next;
        obe_reg     <= obe_next;
        ose_reg     <= ose_next;
        ol_reg      <= ol_next;
    end

    `GLZW_ASSERT_IMP(a_end_flags, ov_reg && ose_reg, obe_reg && ol_reg)
    `GLZW_ASSERT_IMP(a_idle_drained, state_reg == glzw_pkg::S_IDLE, !pend_v_reg && cnt_reg < 5'd8)
    `GLZW_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_reg != glzw_pkg::S_IDLE)

endmodule
